// ----- src/tfd_pkg.sv -----
// ----------------------------------------------------------------------------
// tfd_pkg
// Types and constants shared by the thermal fan / derate controller files.
// ----------------------------------------------------------------------------
package tfd_pkg;

  // Field widths
  localparam int TEMP_W  = 12;
  localparam int DUTY_W  = 8;
  localparam int DER_W   = 9;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 12;

  // Quotient width of the divider (duty is always below 256)
  localparam int QUOT_W = 8;

  // Register reset values
  localparam logic signed [TEMP_W-1:0] FAN_ON_RST  = 12'sd640;
  localparam logic signed [TEMP_W-1:0] FAN_OFF_RST = 12'sd560;

  // Duty line: 30% of 255 at turn-on, 100% at 55 C; scaled by 2 over 2*R
  localparam int DUTY_BASE  = 153;
  localparam int DUTY_SLOPE = 357;

  // Derate full scale
  localparam logic [DER_W-1:0] DER_FULL = 9'd256;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_FAN_ON   = 2'd0,
    CFG_FAN_OFF  = 2'd1,
    CFG_MAN_EN   = 2'd2,
    CFG_MAN_DUTY = 2'd3
  } cfg_idx_e;

  // Shutdown event codes
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_RAISED  = 2'd1,
    EV_CLEARED = 2'd2
  } sd_event_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DUTY_GO,
    S_DUTY_RUN,
    S_DONE
  } state_e;

endpackage

// ----- src/tfd_div.sv -----
// ----------------------------------------------------------------------------
// tfd_div
// Restoring divider, one quotient bit per cycle. The caller guarantees
// that the quotient fits in QUOT_W bits (num < den << QUOT_W).
// ----------------------------------------------------------------------------
module tfd_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [NUM_W-1:0]              num_i,
  input  logic [DEN_W-1:0]              den_i,
  output logic                          done_o,
  output logic [tfd_pkg::QUOT_W-1:0]    quot_o
);

  localparam int QW  = tfd_pkg::QUOT_W;
  localparam int SW  = DEN_W + QW - 1;
  localparam int AW  = (NUM_W > SW) ? NUM_W : SW;
  localparam int CW  = $clog2(QW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] rem_q, rem_d;
  logic [AW-1:0] dsh_q;
  logic [QW-1:0] quot_q, quot_d;
  logic          fits;

  // One compare/subtract step
  always_comb begin
    fits   = (rem_q >= dsh_q);
    rem_d  = fits ? (rem_q - dsh_q) : rem_q;
    quot_d = {quot_q[QW-2:0], fits};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= AW'(num_i);
      dsh_q  <= AW'(den_i) << (QW - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      dsh_q  <= dsh_q >> 1;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- src/thermal_fan_derate_controller.sv -----
// ----------------------------------------------------------------------------
// thermal_fan_derate_controller
// Fan hysteresis, fan duty ramp, power derate and thermal shutdown latch for
// one temperature sample per beat.
// ----------------------------------------------------------------------------
// Sequence: prep, derate multiply and divider start, 8 divider steps, divider
//   done, result load. A new sample is taken only once the last result is
//   loaded; a stalled result holds the next sample at the result load.
// Reset (async, active low): registers to defaults, fan off, no shutdown.
module thermal_fan_derate_controller #(
  parameter int TEMP_FRAC_BITS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tfd_pkg::CIDX_W-1:0]        cfg_index_i,
  input  logic [tfd_pkg::CDATA_W-1:0]       cfg_data_i,
  // Sample input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [tfd_pkg::TEMP_W-1:0] temperature_i,
  // Result output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tfd_pkg::DUTY_W-1:0]        fan_duty_o,
  output logic [tfd_pkg::DER_W-1:0]         power_derate_o,
  output logic                              high_temp_warning_o,
  output logic                              shutdown_active_o,
  output logic [1:0]                        shutdown_event_o
);

  localparam int F     = TEMP_FRAC_BITS;
  localparam int T50_I = 50 << F;
  localparam int T55_I = 55 << F;
  localparam int T65_I = 65 << F;
  // r = T55 - fan_on_temp is at most T55 + 2^11
  localparam int RW    = $clog2(T55_I + 2049);
  localparam int SW    = RW + 2;
  localparam int NW    = ((RW + 9) > (F + 12)) ? (RW + 9) : (F + 12);
  localparam int DW    = RW + 1;
  localparam int TW    = tfd_pkg::TEMP_W;
  localparam int QW    = tfd_pkg::QUOT_W;
  localparam int XW    = RW + 8;

  localparam logic signed [SW-1:0] T50_S = SW'(T50_I);
  localparam logic signed [SW-1:0] T55_S = SW'(T55_I);
  localparam logic signed [SW-1:0] T65_S = SW'(T65_I);
  localparam logic [RW-1:0]        ONE_DEG = RW'(1 << F);
  // 2^16 / 10 rounded up; exact floor for numerators below 2560
  localparam logic [12:0]          DIV10_RECIP = 13'd6554;

  tfd_pkg::state_e state_q, state_d;

  // Configuration registers
  logic signed [TW-1:0]             fan_on_q, fan_off_q;
  logic                             man_en_q;
  logic [tfd_pkg::DUTY_W-1:0]       man_duty_q;

  // Per-sample state
  logic signed [TW-1:0]             t_q;
  logic                             fan_running_q, sd_latched_q;
  logic [RW-1:0]                    r_q, d_q, diff_q;
  logic                             above55_q, ge65_q, warn_q;
  tfd_pkg::sd_event_e               evt_q;
  logic [QW-1:0]                    drop_q, duty_q;

  // Result register
  logic                             out_valid_q;
  logic [tfd_pkg::DUTY_W-1:0]       fan_duty_q;
  logic [tfd_pkg::DER_W-1:0]        derate_q;
  logic                             warn_out_q, sd_out_q;
  tfd_pkg::sd_event_e               evt_out_q;

  // Divider hookup
  logic                             div_start, div_done;
  logic [NW-1:0]                    div_num;
  logic [DW-1:0]                    div_den;
  logic [QW-1:0]                    div_quot;

  logic                             in_acc, out_load;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == tfd_pkg::S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == tfd_pkg::S_DONE) && (!out_valid_q || out_ready_i);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_on_q   <= tfd_pkg::FAN_ON_RST;
      fan_off_q  <= tfd_pkg::FAN_OFF_RST;
      man_en_q   <= 1'b0;
      man_duty_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (tfd_pkg::cfg_idx_e'(cfg_index_i))
        tfd_pkg::CFG_FAN_ON:   fan_on_q   <= cfg_data_i;
        tfd_pkg::CFG_FAN_OFF:  fan_off_q  <= cfg_data_i;
        tfd_pkg::CFG_MAN_EN:   man_en_q   <= cfg_data_i[0];
        tfd_pkg::CFG_MAN_DUTY: man_duty_q <= cfg_data_i[tfd_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Prep step: ramp operands, thresholds, hysteresis and latch decisions
  logic signed [SW-1:0] t_s, on_s, r_s, dd_s, diff_s;
  logic [RW-1:0]        r_v, d_v;
  logic                 fan_next, sd_next;
  tfd_pkg::sd_event_e   evt_next;

  always_comb begin
    t_s    = SW'(t_q);
    on_s   = SW'(fan_on_q);
    r_s    = T55_S - on_s;
    dd_s   = t_s - on_s;
    diff_s = t_s - T55_S;
    r_v    = (r_s <= 0) ? ONE_DEG : r_s[RW-1:0];
    if (dd_s < 0) begin
      d_v = '0;
    end else if (dd_s > SW'(r_v)) begin
      d_v = r_v;
    end else begin
      d_v = dd_s[RW-1:0];
    end
    // Turn-on test wins over turn-off
    fan_next = fan_running_q;
    if (!man_en_q) begin
      if (t_s >= SW'(fan_on_q)) begin
        fan_next = 1'b1;
      end else if (t_s < SW'(fan_off_q)) begin
        fan_next = 1'b0;
      end
    end
    sd_next  = sd_latched_q;
    evt_next = tfd_pkg::EV_NONE;
    if (t_s >= T65_S) begin
      if (!sd_latched_q) begin
        sd_next  = 1'b1;
        evt_next = tfd_pkg::EV_RAISED;
      end
    end else if (t_s < T50_S) begin
      if (sd_latched_q) begin
        sd_next  = 1'b0;
        evt_next = tfd_pkg::EV_CLEARED;
      end
    end
  end

  // Derate drop: difference scaled to 1/256 degree steps, over ten by
  // reciprocal multiply; only meaningful between 55 C and 65 C
  logic [XW-1:0] drop_sh;
  logic [11:0]   drop_x;
  logic [23:0]   drop_p;

  always_comb begin
    drop_sh = {diff_q, 8'd0} >> F;
    drop_x  = drop_sh[11:0];
    drop_p  = 24'(drop_x) * 24'(DIV10_RECIP);
  end

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer next state and divider operand select
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      tfd_pkg::S_IDLE: begin
        if (in_valid_i) state_d = tfd_pkg::S_PREP;
      end
      tfd_pkg::S_PREP: begin
        state_d = tfd_pkg::S_DUTY_GO;
      end
      tfd_pkg::S_DUTY_GO: begin
        div_start = 1'b1;
        div_num   = NW'(r_q) * NW'(tfd_pkg::DUTY_BASE)
                  + NW'(d_q) * NW'(tfd_pkg::DUTY_SLOPE);
        div_den   = {r_q, 1'b0};
        state_d   = tfd_pkg::S_DUTY_RUN;
      end
      tfd_pkg::S_DUTY_RUN: begin
        if (div_done) state_d = tfd_pkg::S_DONE;
      end
      tfd_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = tfd_pkg::S_IDLE;
      end
      default: state_d = tfd_pkg::S_IDLE;
    endcase
  end

  // Divider: duty ratio
  tfd_div #(
    .NUM_W (NW),
    .DEN_W (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Fan and shutdown state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_running_q <= 1'b0;
      sd_latched_q  <= 1'b0;
    end else if (state_q == tfd_pkg::S_PREP) begin
      fan_running_q <= fan_next;
      sd_latched_q  <= sd_next;
    end
  end

  // Sample datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      t_q <= temperature_i;
    end
    if (state_q == tfd_pkg::S_PREP) begin
      r_q       <= r_v;
      d_q       <= d_v;
      diff_q    <= diff_s[RW-1:0];
      above55_q <= (t_s > T55_S);
      ge65_q    <= (t_s >= T65_S);
      warn_q    <= (t_s > T50_S);
      evt_q     <= evt_next;
    end
    if (state_q == tfd_pkg::S_DUTY_GO) begin
      drop_q <= drop_p[QW+15:16];
    end
    if (state_q == tfd_pkg::S_DUTY_RUN && div_done) begin
      duty_q <= div_quot;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (man_en_q) begin
        fan_duty_q <= man_duty_q;
      end else begin
        fan_duty_q <= fan_running_q ? duty_q : '0;
      end
      if (!above55_q) begin
        derate_q <= tfd_pkg::DER_FULL;
      end else if (ge65_q) begin
        derate_q <= '0;
      end else begin
        derate_q <= tfd_pkg::DER_FULL - tfd_pkg::DER_W'(drop_q);
      end
      warn_out_q <= warn_q;
      sd_out_q   <= sd_latched_q;
      evt_out_q  <= evt_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign fan_duty_o          = fan_duty_q;
  assign power_derate_o      = derate_q;
  assign high_temp_warning_o = warn_out_q;
  assign shutdown_active_o   = sd_out_q;
  assign shutdown_event_o    = evt_out_q;

endmodule

// ----- src/tfd_checker.sv -----
// ----------------------------------------------------------------------------
// tfd_checker
// Port-level checks for the thermal fan / derate controller.
// ----------------------------------------------------------------------------
module tfd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [tfd_pkg::DUTY_W-1:0]        fan_duty_o,
  input logic [tfd_pkg::DER_W-1:0]         power_derate_o,
  input logic                              high_temp_warning_o,
  input logic                              shutdown_active_o,
  input logic [1:0]                        shutdown_event_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fan_duty_o)
      && $stable(power_derate_o) && $stable(shutdown_event_o))
    else $error("result beat changed while stalled");

  // A raise happens at 65 C or more: latch set, warning set, no power
  a_raise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && shutdown_event_o == tfd_pkg::EV_RAISED |->
      shutdown_active_o && high_temp_warning_o && power_derate_o == '0)
    else $error("shutdown raise inconsistent");

  // A clear happens below 50 C: latch clear, no warning, full power
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && shutdown_event_o == tfd_pkg::EV_CLEARED |->
      !shutdown_active_o && !high_temp_warning_o
      && power_derate_o == tfd_pkg::DER_FULL)
    else $error("shutdown clear inconsistent");

  // Derate never exceeds full scale
  a_derate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> power_derate_o <= tfd_pkg::DER_FULL)
    else $error("derate out of range");

endmodule

bind thermal_fan_derate_controller tfd_checker u_tfd_checker (.*);

// ----- test/tfd_result_checker.sv -----
// ----------------------------------------------------------------------------
// tfd_result_checker
// Watches the configuration, sample and result channels of the thermal fan /
// derate controller. Keeps its own copy of the registers, the fan hysteresis
// flag and the shutdown latch, works out the result for every accepted sample
// and compares each accepted result beat against the oldest one waiting.
// ----------------------------------------------------------------------------
module tfd_result_checker
  import tfd_pkg::*;
#(
  parameter int TEMP_FRAC_BITS = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CIDX_W-1:0]        cfg_index_i,
  input  logic [CDATA_W-1:0]       cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic signed [TEMP_W-1:0] temperature_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [DUTY_W-1:0]        fan_duty_i,
  input  logic [DER_W-1:0]         power_derate_i,
  input  logic                     high_temp_warning_i,
  input  logic                     shutdown_active_i,
  input  logic [1:0]               shutdown_event_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       samples_o,
  output int                       results_o
);

  // Temperature points in sample units
  localparam int ONE_DEG = 1 << TEMP_FRAC_BITS;
  localparam int TEMP_50 = 50 * ONE_DEG;
  localparam int TEMP_55 = 55 * ONE_DEG;
  localparam int TEMP_65 = 65 * ONE_DEG;
  localparam int SPAN_10 = 10 * ONE_DEG;

  // Duty ramp: 30% of 255 at turn-on, full at 55 C, both doubled over 2*span
  localparam int RAMP_BASE  = 153;
  localparam int RAMP_SLOPE = 357;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [DER_W-1:0]  derate;
    logic              warn;
    logic              shut;
    logic [1:0]        ev;
  } thermal_result_t;

  // Register copies
  int                on_temp;
  int                off_temp;
  logic              man_en;
  logic [DUTY_W-1:0] man_duty;

  // Block state copies
  logic fan_on;
  logic latched;

  thermal_result_t pending_results_q[$];
  int              mismatches;

  // Result for one sample; advances the fan flag and the shutdown latch
  function automatic thermal_result_t thermal_response(input logic signed [TEMP_W-1:0] temp);
    thermal_result_t res;
    int t;
    int span;
    int over;
    int drop;
    t      = temp;
    res.ev = EV_NONE;

    // fan duty, hysteresis skipped under manual override
    if (man_en) begin
      res.duty = man_duty;
    end else begin
      if (t >= on_temp) begin
        fan_on = 1'b1;
      end else if (t < off_temp) begin
        fan_on = 1'b0;
      end
      if (fan_on) begin
        span = TEMP_55 - on_temp;
        if (span <= 0) span = ONE_DEG;
        over = t - on_temp;
        if (over < 0) over = 0;
        if (over > span) over = span;
        res.duty = DUTY_W'((RAMP_BASE * span + RAMP_SLOPE * over) / (2 * span));
      end else begin
        res.duty = '0;
      end
    end

    // power derate above 55 C
    if (t > TEMP_55) begin
      drop       = ((t - TEMP_55) * 256) / SPAN_10;
      res.derate = (drop >= 256) ? '0 : DER_W'(256 - drop);
    end else begin
      res.derate = DER_FULL;
    end

    // shutdown latch and its events
    if (t >= TEMP_65) begin
      if (!latched) begin
        latched = 1'b1;
        res.ev  = EV_RAISED;
      end
    end else if (t < TEMP_50) begin
      if (latched) begin
        latched = 1'b0;
        res.ev  = EV_CLEARED;
      end
    end

    res.warn = (t > TEMP_50);
    res.shut = latched;
    return res;
  endfunction

  // Channel monitor
  always @(posedge clk_i or negedge rst_ni) begin
    thermal_result_t want_r;
    thermal_result_t seen_r;
    if (!rst_ni) begin
      on_temp      = FAN_ON_RST;
      off_temp     = FAN_OFF_RST;
      man_en       = 1'b0;
      man_duty     = '0;
      fan_on       = 1'b0;
      latched      = 1'b0;
      mismatches   = 0;
      fail_count_o = 0;
      samples_o    = 0;
      results_o    = 0;
      pending_results_q.delete();
      pending_o    = 0;
    end else begin
      // register write beat
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FAN_ON:   on_temp  = $signed(cfg_data_i);
          CFG_FAN_OFF:  off_temp = $signed(cfg_data_i);
          CFG_MAN_EN:   man_en   = cfg_data_i[0];
          CFG_MAN_DUTY: man_duty = cfg_data_i[DUTY_W-1:0];
          default: ;
        endcase
      end

      // sample beat
      if (in_valid_i && in_ready_i) begin
        pending_results_q.push_back(thermal_response(temperature_i));
        samples_o++;
      end

      // result beat
      if (out_valid_i && out_ready_i) begin
        results_o++;
        seen_r = '{fan_duty_i, power_derate_i, high_temp_warning_i, shutdown_active_i,
                   shutdown_event_i};
        if (pending_results_q.size() == 0) begin
          fail_count_o++;
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with no sample outstanding: duty %0d derate %0d",
                     results_o, fan_duty_i, power_derate_i);
        end else begin
          want_r = pending_results_q.pop_front();
          if (seen_r.duty !== want_r.duty || seen_r.derate !== want_r.derate ||
              seen_r.warn !== want_r.warn || seen_r.shut !== want_r.shut ||
              seen_r.ev !== want_r.ev) begin
            fail_count_o++;
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d mismatch: expected duty %0d derate %0d warn %0b shut %0b ev %0d",
                       results_o, want_r.duty, want_r.derate, want_r.warn, want_r.shut,
                       want_r.ev);
              $display("    got duty %0d derate %0d warn %0b shut %0b ev %0d",
                       seen_r.duty, seen_r.derate, seen_r.warn, seen_r.shut, seen_r.ev);
            end
          end
        end
      end
      pending_o = pending_results_q.size();
    end
  end

endmodule

// ----- test/thermal_fan_derate_controller_tb.sv -----
// ----------------------------------------------------------------------------
// thermal_fan_derate_controller_tb
// Drives temperature samples and register writes into the controller under
// changing handshake pacing, including a long output stall, while the result
// checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module thermal_fan_derate_controller_tb;
  import tfd_pkg::*;

  localparam int ITEMS_PER_SETTING = 108;
  localparam int LONG_HOLD         = 300;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CIDX_W-1:0]        cfg_index = '0;
  logic [CDATA_W-1:0]       cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [TEMP_W-1:0] temperature = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [DUTY_W-1:0]        fan_duty;
  logic [DER_W-1:0]         power_derate;
  logic                     high_temp_warning;
  logic                     shutdown_active;
  logic [1:0]               shutdown_event;

  int fail_count;
  int pending;
  int samples;
  int results;

  // pacing knobs, written by the stimulus only
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;

  // receiver-owned hold bookkeeping
  int hold_seen = 0;
  int hold_left = 0;

  // stimulus copy of the thresholds, used to aim samples
  int cur_on  = 640;
  int cur_off = 560;
  int settings_run = 0;

  always #2 clk = ~clk;

  thermal_fan_derate_controller u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .temperature_i       (temperature),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .fan_duty_o          (fan_duty),
    .power_derate_o      (power_derate),
    .high_temp_warning_o (high_temp_warning),
    .shutdown_active_o   (shutdown_active),
    .shutdown_event_o    (shutdown_event)
  );

  tfd_result_checker u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .temperature_i       (temperature),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .fan_duty_i          (fan_duty),
    .power_derate_i      (power_derate),
    .high_temp_warning_i (high_temp_warning),
    .shutdown_active_i   (shutdown_active),
    .shutdown_event_i    (shutdown_event),
    .fail_count_o        (fail_count),
    .pending_o           (pending),
    .samples_o           (samples),
    .results_o           (results)
  );

  // Result side: random stalls, plus a long hold on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One sample beat; entered and left at a falling edge, valid left high
  task automatic send_temp(input logic signed [TEMP_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    temperature <= t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // One register beat; valid left high for a following write
  task automatic write_reg(input cfg_idx_e idx, input logic [CDATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Wait at falling edges until every sample has its result back
  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  // Write all four registers; upper data bits of the narrow ones are noise
  task automatic apply_setting(input int on_t, input int off_t, input logic en,
                               input logic [DUTY_W-1:0] duty);
    cur_on  = on_t;
    cur_off = off_t;
    write_reg(CFG_FAN_ON, CDATA_W'(on_t));
    write_reg(CFG_FAN_OFF, CDATA_W'(off_t));
    write_reg(CFG_MAN_EN, {11'($urandom), en});
    write_reg(CFG_MAN_DUTY, {4'($urandom), duty});
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // Random sample, partly aimed at the thresholds in use
  function automatic logic signed [TEMP_W-1:0] rand_temp();
    int sel;
    int v;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2: v = $urandom;
      3, 4, 5: v = 500 + $urandom_range(700);
      6, 7:    v = cur_on - 3 + $urandom_range(6);
      8:       v = cur_off - 3 + $urandom_range(6);
      default: begin
        case ($urandom_range(2))
          0:       v = 800;
          1:       v = 880;
          default: v = 1040;
        endcase
        v = v - 1 + $urandom_range(2);
      end
    endcase
    return TEMP_W'(v);
  endfunction

  // Timeout
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // Stimulus
  initial begin
    int edge_temps[$];
    int ph;
    int k;
    int sel_idx;
    edge_temps = '{-2048, 640, 641, 879, 880, 881, 1039, 1040, 1041, 800, 799, 560, 559,
                   2047, 1365, -1366, 0, 801};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes and thresholds at reset settings
    send_idle_pct = 28;
    recv_idle_pct = 48;
    foreach (edge_temps[i]) send_temp(TEMP_W'(edge_temps[i]));
    in_valid <= 1'b0;
    drain();

    // directed: manual override at both duty extremes
    apply_setting(640, 560, 1'b1, 8'd255);
    send_temp(12'sd1000);
    send_temp(-12'sd2048);
    in_valid <= 1'b0;
    drain();
    apply_setting(640, 560, 1'b1, 8'd0);
    send_temp(12'sd2047);
    in_valid <= 1'b0;
    drain();

    // directed: turn-on above 55 C, empty ramp falls back to one degree
    apply_setting(900, 850, 1'b0, 8'd0);
    send_temp(12'sd880);
    send_temp(12'sd900);
    send_temp(12'sd916);
    send_temp(12'sd849);
    in_valid <= 1'b0;
    drain();

    // random: three pacing phases, three settings each
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 28; recv_idle_pct = 48; end
        1: begin send_idle_pct = 48; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (k = 0; k < 3; k++) begin
        drain();
        sel_idx = ph * 3 + k;
        case (sel_idx)
          0: apply_setting(640, 560, 1'b0, 8'd0);
          1: apply_setting(-2048, 2047, 1'b0, 8'd255);
          2: apply_setting(2047, -2048, 1'b0, 8'h5a);
          3: apply_setting(900, 850, 1'b0, 8'd17);
          4: apply_setting(879, 700, 1'b0, 8'd0);
          5: apply_setting(640, 560, 1'b1, 8'd255);
          6: apply_setting(300, 400, 1'b1, 8'd0);
          7: apply_setting(200, 100, 1'b0, 8'ha5);
          default: apply_setting($signed(12'($urandom)), $signed(12'($urandom)),
                                 ($urandom_range(3) == 0), 8'($urandom));
        endcase
        // long output stall while samples keep coming
        if (sel_idx == 0) hold_req++;
        repeat (ITEMS_PER_SETTING) send_temp(rand_temp());
        in_valid <= 1'b0;
      end
    end

    recv_idle_pct = 0;
    drain();
    repeat (40) @(negedge clk);

    $display("Ran %0d samples and checked %0d results over %0d register settings,",
             samples, results, settings_run);
    $display("with three pacing phases and a %0d-cycle output stall.", LONG_HOLD);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
